// ----- rtl/malt_pkg.sv -----
package malt_pkg;

    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_COMMA  = 8'h2C;
    localparam logic [7:0] CH_LANGLE = 8'h3C;
    localparam logic [7:0] CH_RANGLE = 8'h3E;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_TAB    = 8'h09;
    localparam logic [7:0] CH_CR     = 8'h0D;
    localparam logic [7:0] DEPTH_MAX = 8'hFF;

    typedef enum logic {
        ST_COLLECT,
        ST_DRAIN
    } t_state;

    typedef struct packed {
        logic       in_quote;
        logic       escape_pending;
        logic [7:0] comment_depth;
        logic       angle_open;
        logic       angle_closed;
    } t_parse_st;

    localparam t_parse_st PARSE_RESET = '{
        in_quote:       1'b0,
        escape_pending: 1'b0,
        comment_depth:  8'h00,
        angle_open:     1'b0,
        angle_closed:   1'b0
    };

    typedef struct packed {
        logic collect;
        logic restart;
        logic emit;
    } t_action;

endpackage

// ----- rtl/malt_parse.sv -----
module malt_parse (
    input  malt_pkg::t_parse_st i_state,
    input  logic [7:0]          i_char,
    input  logic                i_last,
    output malt_pkg::t_parse_st o_state,
    output malt_pkg::t_action   o_act
);

    logic is_blank;
    logic want_collect;
    logic is_comma;

    assign is_blank = (i_char == malt_pkg::CH_SPACE) ||
                      (i_char inside {[malt_pkg::CH_TAB:malt_pkg::CH_CR]});

    always_comb begin
        malt_pkg::t_parse_st st;
        st           = i_state;
        want_collect = 1'b0;
        is_comma     = 1'b0;
        o_act        = '0;
        if (i_state.comment_depth != 8'h00) begin
            if (i_char == malt_pkg::CH_LPAREN) begin
                if (i_state.comment_depth != malt_pkg::DEPTH_MAX) begin
                    st.comment_depth = i_state.comment_depth + 8'd1;
                end
            end else if (i_char == malt_pkg::CH_RPAREN) begin
                st.comment_depth = i_state.comment_depth - 8'd1;
            end
        end else if (i_state.escape_pending) begin
            st.escape_pending = 1'b0;
            want_collect      = 1'b1;
        end else if (i_char == malt_pkg::CH_QUOTE) begin
            st.in_quote = ~i_state.in_quote;
        end else if (i_char == malt_pkg::CH_BSLASH && !i_last) begin
            st.escape_pending = 1'b1;
        end else if (i_state.in_quote) begin
            want_collect = 1'b1;
        end else if (i_char == malt_pkg::CH_LPAREN) begin
            st.comment_depth = 8'd1;
        end else if (i_char == malt_pkg::CH_COMMA) begin
            is_comma = 1'b1;
        end else if (is_blank) begin
            st = i_state;
        end else if (i_char == malt_pkg::CH_LANGLE) begin
            if (!i_state.angle_open) begin
                st.angle_open = 1'b1;
                o_act.restart = 1'b1;
            end
        end else if (i_char == malt_pkg::CH_RANGLE && i_state.angle_open) begin
            st.angle_closed = 1'b1;
        end else begin
            want_collect = 1'b1;
        end
        o_act.collect = want_collect && !i_state.angle_closed;
        o_act.emit    = is_comma || i_last;
        o_state       = o_act.emit ? malt_pkg::PARSE_RESET : st;
    end

endmodule

// ----- rtl/mail_address_list_tokenizer_core.sv -----
// Channel   Dir  Bus signals                   Item
// input     in   s_axis_tvalid/tready          tdata[7:0] in_char, tlast line_end
// result    out  m_axis_tvalid/tready          tdata[7:0] addr_char, tlast token_last,
//                                              tuser[0] token_empty, tuser[1] truncated
// An input item is taken whenever the block is collecting and no read is pending.
// At a comma or line end the token is read back from the token memory one character at a
// time; a new read waits until the last one has passed the registered read port into the output register.
// The input is held off until the last character of a token is in the output register.
// Reset is synchronous and active low; the token memory is not cleared.
// A stalled output holds its item and pauses the readback.
module mail_address_list_tokenizer_core #(
    parameter int TOKEN_LEN = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,  // [7:0] in_char
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,  // [7:0] addr_char
    output logic [1:0] m_axis_tuser,  // [0] token_empty, [1] truncated
    output logic       m_axis_tlast
);

    localparam int AW = $clog2(TOKEN_LEN);
    localparam int CW = $clog2(TOKEN_LEN + 1);
    localparam logic [CW-1:0] LEN_C = CW'(TOKEN_LEN);

    malt_pkg::t_state    r_state, n_state;
    malt_pkg::t_parse_st r_pst, n_pst;
    malt_pkg::t_parse_st w_pst_step;
    malt_pkg::t_action   w_act;

    logic [CW-1:0] r_count, n_count;
    logic          r_ovf, n_ovf;
    logic [CW-1:0] r_dcnt, n_dcnt;
    logic          r_dovf, n_dovf;
    logic [CW-1:0] r_idx, n_idx;

    logic [7:0] r_mem [TOKEN_LEN];
    logic [7:0] r_rd_data;
    logic       r_rd_pend;
    logic       r_rd_last;

    logic       r_ovalid;
    logic [7:0] r_ochar;
    logic       r_olast;
    logic       r_oempty;
    logic       r_otrunc;

    logic w_accept;
    logic w_out_free;
    logic w_issue;
    logic w_issue_last;
    logic w_load_empty;
    logic w_store;

    malt_parse u_parse (
        .i_state (r_pst),
        .i_char  (s_axis_tdata),
        .i_last  (s_axis_tlast),
        .o_state (w_pst_step),
        .o_act   (w_act)
    );

    assign s_axis_tready = (r_state == malt_pkg::ST_COLLECT) && !r_rd_pend;
    assign w_accept      = s_axis_tvalid && s_axis_tready;
    assign w_out_free    = !r_ovalid || m_axis_tready;
    assign w_store       = w_accept && w_act.collect && (r_count < LEN_C);
    assign w_issue_last  = (CW'(r_idx + CW'(1)) == r_dcnt);

    always_comb begin
        n_state      = r_state;
        n_pst        = r_pst;
        n_count      = r_count;
        n_ovf        = r_ovf;
        n_dcnt       = r_dcnt;
        n_dovf       = r_dovf;
        n_idx        = r_idx;
        w_issue      = 1'b0;
        w_load_empty = 1'b0;
        case (r_state)
            malt_pkg::ST_COLLECT: begin
                if (w_accept) begin
                    if (w_act.restart) begin
                        n_count = '0;
                        n_ovf   = 1'b0;
                    end else if (w_act.collect) begin
                        if (r_count < LEN_C) begin
                            n_count = CW'(r_count + CW'(1));
                        end else begin
                            n_ovf = 1'b1;
                        end
                    end
                    n_pst = w_pst_step;
                    if (w_act.emit) begin
                        n_dcnt  = n_count;
                        n_dovf  = n_ovf;
                        n_idx   = '0;
                        n_count = '0;
                        n_ovf   = 1'b0;
                        n_state = malt_pkg::ST_DRAIN;
                    end
                end
            end
            malt_pkg::ST_DRAIN: begin
                if (r_dcnt == '0) begin
                    if (w_out_free) begin
                        w_load_empty = 1'b1;
                        n_state      = malt_pkg::ST_COLLECT;
                    end
                end else if (!r_rd_pend && w_out_free) begin
                    w_issue = 1'b1;
                    n_idx   = CW'(r_idx + CW'(1));
                    if (w_issue_last) begin
                        n_state = malt_pkg::ST_COLLECT;
                    end
                end
            end
            default: begin
                n_state = malt_pkg::ST_COLLECT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= malt_pkg::ST_COLLECT;
            r_pst   <= malt_pkg::PARSE_RESET;
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_dcnt  <= '0;
            r_dovf  <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_pst   <= n_pst;
            r_count <= n_count;
            r_ovf   <= n_ovf;
            r_dcnt  <= n_dcnt;
            r_dovf  <= n_dovf;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_store) begin
            r_mem[r_count[AW-1:0]] <= s_axis_tdata;
        end
        if (w_issue) begin
            r_rd_data <= r_mem[r_idx[AW-1:0]];
            r_rd_last <= w_issue_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_pend <= 1'b0;
            r_ovalid  <= 1'b0;
        end else begin
            r_rd_pend <= w_issue;
            if (r_rd_pend || w_load_empty) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_rd_pend) begin
            r_ochar  <= r_rd_data;
            r_olast  <= r_rd_last;
            r_oempty <= 1'b0;
            r_otrunc <= r_dovf;
        end else if (w_load_empty) begin
            r_ochar  <= 8'h00;
            r_olast  <= 1'b1;
            r_oempty <= 1'b1;
            r_otrunc <= r_dovf;
        end
    end

    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_ochar;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tuser  = {r_otrunc, r_oempty};

endmodule
